// ===== src/rbo_pkg.sv =====
// rbo_pkg: shared constants for the ray/box overlap test pipeline
// no dependencies; imported by ray_box_overlap_test
`timescale 1ns / 1ps
`default_nettype none

package rbo_pkg;

  localparam int unsigned CoordWidthDefault = 32;
  localparam int unsigned NumAxes           = 3;
  localparam int unsigned NumStages         = 6;
  localparam int unsigned ProdsPerAxis      = 4;

endpackage

`default_nettype wire

// ===== src/ray_box_overlap_test.sv =====
// ray_box_overlap_test: pipelined ray versus axis-aligned box separating-axis test
// depends on rbo_pkg for default width and stage counts
//
// usage: one query beat on the input channel carries a ray start, a ray direction and
// the min and max box corners as signed fixed point; one result beat carries hit_o.
// both channels use valid and stall: a beat moves on a rising edge with valid high and
// stall low. the receiver drives stall.
// throughput is one beat per cycle while the receiver does not drive stall.
// the six register stages are: doubled offset and extent, split partial products and
// slab checks, product assembly, cross difference and bound sum, magnitude, compare.
// each stage carries its own valid bit, so a stalled output only holds the stages that
// are full; empty stages keep filling, and in_stall_o rises only once all six are full.
// nothing is lost or repeated under stall; a stalled result holds steady.
// reset clears all stage valid bits; the data registers are not reset.
// the fraction position of the coordinates changes no result, since a common scale
// cancels in every comparison.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_overlap_test
  import rbo_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               hit_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned EW  = W + 1;          // doubled extent
  localparam int unsigned DW  = W + 2;          // doubled offset from center
  localparam int unsigned AW  = W + 1;          // multiplier a operand
  localparam int unsigned BW  = W + 2;          // multiplier b operand
  localparam int unsigned LW  = BW / 2;         // low split of b
  localparam int unsigned HW  = BW - LW;        // high split of b
  localparam int unsigned PW  = AW + BW;        // full product
  localparam int unsigned NP  = NumAxes * ProdsPerAxis;

  // stage handshake
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < int'(NumStages); i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NumStages-1];

  // stage 1: doubled extent, doubled offset, direction magnitude
  logic signed [W-1:0] st [NumAxes];
  logic signed [W-1:0] dr [NumAxes];
  logic signed [W-1:0] bl [NumAxes];
  logic signed [W-1:0] bh [NumAxes];

  assign st[0] = start_x_i;
  assign st[1] = start_y_i;
  assign st[2] = start_z_i;
  assign dr[0] = dir_x_i;
  assign dr[1] = dir_y_i;
  assign dr[2] = dir_z_i;
  assign bl[0] = box_min_x_i;
  assign bl[1] = box_min_y_i;
  assign bl[2] = box_min_z_i;
  assign bh[0] = box_max_x_i;
  assign bh[1] = box_max_y_i;
  assign bh[2] = box_max_z_i;

  logic signed [EW-1:0] e2_d   [NumAxes];
  logic signed [EW-1:0] e2_q   [NumAxes];
  logic signed [DW-1:0] d2_d   [NumAxes];
  logic signed [DW-1:0] d2_q   [NumAxes];
  logic        [W-1:0]  adir_d [NumAxes];
  logic        [W-1:0]  adir_q [NumAxes];
  logic signed [W-1:0]  dir_q  [NumAxes];

  always_comb begin
    for (int a = 0; a < int'(NumAxes); a++) begin
      e2_d[a]   = EW'(bh[a]) - EW'(bl[a]);
      d2_d[a]   = $signed({st[a][W-1], st[a], 1'b0}) - (DW'(bl[a]) + DW'(bh[a]));
      adir_d[a] = dr[a][W-1] ? W'(-EW'(dr[a])) : W'(dr[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      e2_q   <= e2_d;
      d2_q   <= d2_d;
      adir_q <= adir_d;
      dir_q  <= dr;
    end
  end

  // stage 2: slab rejection and split partial products
  logic signed [AW-1:0]      mul_a [NP];
  logic signed [BW-1:0]      mul_b [NP];
  logic signed [AW+LW:0]     pl_q  [NP];
  logic signed [AW+HW-1:0]   ph_q  [NP];
  logic                      slab_d;
  logic                      slab2_q;

  for (genvar k = 0; k < NumAxes; k++) begin : g_ops
    localparam int unsigned B = (k == 0) ? 1 : ((k == 1) ? 2 : 0);
    localparam int unsigned C = (k == 0) ? 2 : ((k == 1) ? 0 : 1);
    assign mul_a[ProdsPerAxis*k]     = AW'(dir_q[B]);
    assign mul_b[ProdsPerAxis*k]     = d2_q[C];
    assign mul_a[ProdsPerAxis*k + 1] = AW'(dir_q[C]);
    assign mul_b[ProdsPerAxis*k + 1] = d2_q[B];
    assign mul_a[ProdsPerAxis*k + 2] = e2_q[B];
    assign mul_b[ProdsPerAxis*k + 2] = $signed(BW'(adir_q[C]));
    assign mul_a[ProdsPerAxis*k + 3] = e2_q[C];
    assign mul_b[ProdsPerAxis*k + 3] = $signed(BW'(adir_q[B]));
  end

  always_comb begin
    logic [DW-1:0] mag;
    logic          outside;
    logic          away;
    slab_d = 1'b0;
    for (int a = 0; a < int'(NumAxes); a++) begin
      mag     = d2_q[a][DW-1] ? DW'(-d2_q[a]) : DW'(d2_q[a]);
      outside = $signed({1'b0, mag}) > $signed((DW+1)'(e2_q[a]));
      away    = (d2_q[a] == '0) || (dir_q[a] == '0) || (d2_q[a][DW-1] == dir_q[a][W-1]);
      slab_d  = slab_d | (outside & away);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      slab2_q <= slab_d;
      for (int j = 0; j < int'(NP); j++) begin
        pl_q[j] <= (AW+LW+1)'(mul_a[j])
                 * (AW+LW+1)'($signed({1'b0, mul_b[j][LW-1:0]}));
        ph_q[j] <= (AW+HW)'(mul_a[j])
                 * (AW+HW)'($signed(mul_b[j][BW-1:LW]));
      end
    end
  end

  // stage 3: product assembly
  logic signed [PW-1:0] prod_q [NP];
  logic                 slab3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      slab3_q <= slab2_q;
      for (int j = 0; j < int'(NP); j++) begin
        prod_q[j] <= $signed({ph_q[j], {LW{1'b0}}}) + PW'(pl_q[j]);
      end
    end
  end

  // stage 4: cross difference and bound sum
  logic signed [PW:0] f_q   [NumAxes];
  logic signed [PW:0] bnd_q [NumAxes];
  logic               slab4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      slab4_q <= slab3_q;
      for (int k = 0; k < int'(NumAxes); k++) begin
        f_q[k]   <= (PW+1)'(prod_q[ProdsPerAxis*k])
                  - (PW+1)'(prod_q[ProdsPerAxis*k + 1]);
        bnd_q[k] <= (PW+1)'(prod_q[ProdsPerAxis*k + 2])
                  + (PW+1)'(prod_q[ProdsPerAxis*k + 3]);
      end
    end
  end

  // stage 5: magnitude of cross term
  logic        [PW:0] af_q   [NumAxes];
  logic signed [PW:0] bnd5_q [NumAxes];
  logic               slab5_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      slab5_q <= slab4_q;
      bnd5_q  <= bnd_q;
      for (int k = 0; k < int'(NumAxes); k++) begin
        af_q[k] <= f_q[k][PW] ? (PW+1)'(-f_q[k]) : (PW+1)'(f_q[k]);
      end
    end
  end

  // stage 6: axis compares into the output register
  logic [NumAxes-1:0] over;
  logic               hit_d;
  logic               hit_q;

  always_comb begin
    for (int k = 0; k < int'(NumAxes); k++) begin
      over[k] = $signed({1'b0, af_q[k]}) > $signed((PW+2)'(bnd5_q[k]));
    end
    hit_d = !slab5_q && !over[0] && !over[1]
         && ($signed((PW+2)'(bnd5_q[2])) > $signed({1'b0, af_q[2]}));
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

// ===== tb/rbo_hit_checker.sv =====
// rbo_hit_checker: watches the query and result channels of ray_box_overlap_test,
// predicts the hit flag of every accepted query and compares it with the result beats
// depends on rbo_pkg for the default coordinate width
`timescale 1ns / 1ps

module rbo_hit_checker
  import rbo_pkg::*;
#(
  parameter int unsigned W = CoordWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic signed [W-1:0] start_x_i,
  input  logic signed [W-1:0] start_y_i,
  input  logic signed [W-1:0] start_z_i,
  input  logic signed [W-1:0] dir_x_i,
  input  logic signed [W-1:0] dir_y_i,
  input  logic signed [W-1:0] dir_z_i,
  input  logic signed [W-1:0] box_min_x_i,
  input  logic signed [W-1:0] box_min_y_i,
  input  logic signed [W-1:0] box_min_z_i,
  input  logic signed [W-1:0] box_max_x_i,
  input  logic signed [W-1:0] box_max_y_i,
  input  logic signed [W-1:0] box_max_z_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                hit_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int unsigned WIDE = 4 * W;
  typedef logic signed [WIDE-1:0] wide_t;

  logic hit_expected_q[$];
  logic exp_hit;
  int   fail_cnt = 0;
  int   pending_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  function automatic wide_t mag(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // doubled center offsets and extents, slab rejections, then the three cross axes
  function automatic logic ray_meets_box(
    input logic signed [W-1:0] sx, sy, sz, dx, dy, dz,
    input logic signed [W-1:0] lx, ly, lz, hx, hy, hz
  );
    wide_t s[3], d[3], lo[3], hi[3], e2[3], c2[3], ad[3];
    wide_t f, bnd;
    logic  miss;
    s[0] = wide_t'(sx);  s[1] = wide_t'(sy);  s[2] = wide_t'(sz);
    d[0] = wide_t'(dx);  d[1] = wide_t'(dy);  d[2] = wide_t'(dz);
    lo[0] = wide_t'(lx); lo[1] = wide_t'(ly); lo[2] = wide_t'(lz);
    hi[0] = wide_t'(hx); hi[1] = wide_t'(hy); hi[2] = wide_t'(hz);
    miss = 1'b0;
    for (int i = 0; i < 3; i++) begin
      e2[i] = hi[i] - lo[i];
      c2[i] = s[i] + s[i] - (lo[i] + hi[i]);
      ad[i] = mag(d[i]);
      if (mag(c2[i]) > e2[i] &&
          (c2[i] == 0 || d[i] == 0 || ((c2[i] < 0) == (d[i] < 0)))) begin
        miss = 1'b1;
      end
    end
    f   = mag(d[1] * c2[2] - d[2] * c2[1]);
    bnd = e2[1] * ad[2] + e2[2] * ad[1];
    if (f > bnd) miss = 1'b1;
    f   = mag(d[2] * c2[0] - d[0] * c2[2]);
    bnd = e2[0] * ad[2] + e2[2] * ad[0];
    if (f > bnd) miss = 1'b1;
    f   = mag(d[0] * c2[1] - d[1] * c2[0]);
    bnd = e2[0] * ad[1] + e2[1] * ad[0];
    if (!(bnd > f)) miss = 1'b1;
    return !miss;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        hit_expected_q.push_back(ray_meets_box(
          start_x_i, start_y_i, start_z_i, dir_x_i, dir_y_i, dir_z_i,
          box_min_x_i, box_min_y_i, box_min_z_i, box_max_x_i, box_max_y_i, box_max_z_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (hit_expected_q.size() == 0) begin
          if (fail_cnt < 10) $display("%0t: result beat with no query pending, hit %0b",
                                      $realtime, hit_i);
          fail_cnt++;
        end else begin
          exp_hit = hit_expected_q.pop_front();
          if (hit_i !== exp_hit) begin
            if (fail_cnt < 10) $display("%0t: hit mismatch, expected %0b got %0b",
                                        $realtime, exp_hit, hit_i);
            fail_cnt++;
          end
        end
      end
      pending_cnt <= hit_expected_q.size();
    end
  end

endmodule

// ===== tb/ray_box_overlap_test_tb.sv =====
// ray_box_overlap_test_tb: drives directed and random ray/box queries into
// ray_box_overlap_test under varying idle and stall patterns and gives the verdict
// depends on rbo_pkg, ray_box_overlap_test and rbo_hit_checker
`timescale 1ns / 1ps

module ray_box_overlap_test_tb;
  import rbo_pkg::*;

  localparam int unsigned W           = CoordWidthDefault;
  localparam int          LATENCY     = NumStages;
  localparam int          HOLD_CYCLES = 150;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          RAND_ITEMS  = 510;
  localparam int          ONE         = 65536;
  localparam int          CMAX        = 32'h7fffffff;
  localparam int          CMIN        = 32'h80000000;

  typedef struct packed {
    logic signed [W-1:0] sx, sy, sz, dx, dy, dz, lx, ly, lz, hx, hy, hz;
  } ray_query_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       out_stall = 1'b0;
  ray_query_t q_drv = '0;
  logic       in_stall, out_valid, hit;
  int         fail_count, pending;
  int         sender_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ray_box_overlap_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .start_x_i   (q_drv.sx),
    .start_y_i   (q_drv.sy),
    .start_z_i   (q_drv.sz),
    .dir_x_i     (q_drv.dx),
    .dir_y_i     (q_drv.dy),
    .dir_z_i     (q_drv.dz),
    .box_min_x_i (q_drv.lx),
    .box_min_y_i (q_drv.ly),
    .box_min_z_i (q_drv.lz),
    .box_max_x_i (q_drv.hx),
    .box_max_y_i (q_drv.hy),
    .box_max_z_i (q_drv.hz),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .hit_o       (hit)
  );

  rbo_hit_checker #(.W(W)) u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .start_x_i    (q_drv.sx),
    .start_y_i    (q_drv.sy),
    .start_z_i    (q_drv.sz),
    .dir_x_i      (q_drv.dx),
    .dir_y_i      (q_drv.dy),
    .dir_z_i      (q_drv.dz),
    .box_min_x_i  (q_drv.lx),
    .box_min_y_i  (q_drv.ly),
    .box_min_z_i  (q_drv.lz),
    .box_max_x_i  (q_drv.hx),
    .box_max_y_i  (q_drv.hy),
    .box_max_z_i  (q_drv.hz),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .hit_i        (hit),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = (int'($urandom_range(99)) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ray_box_overlap_test_tb failed");
        $finish;
      end
    end
  end

  task automatic send_query(input ray_query_t q);
    forever begin
      @(negedge clk_i);
      if (int'($urandom_range(99)) < sender_idle_pct) begin
        in_valid = 1'b0;
      end else begin
        q_drv    = q;
        in_valid = 1'b1;
        break;
      end
    end
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_fields(input int sx, sy, sz, dx, dy, dz, lx, ly, lz, hx, hy, hz);
    ray_query_t q;
    q = '{sx, sy, sz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
    send_query(q);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(5))
      0:       return CMAX;
      1:       return CMIN;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic ray_query_t random_query();
    ray_query_t q;
    int c, h, t, s, d, tmp, kind;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // box around a random center, ray usually aimed at a point near or inside it
      for (int a = 0; a < 3; a++) begin
        c = int'($urandom_range(2097152)) - 1048576;
        h = $urandom_range(1, 65536);
        t = c + int'($urandom_range(2 * h + 4096)) - h - 2048;
        s = c + int'($urandom_range(1048576)) - 524288;
        d = t - s;
        if ($urandom_range(9) == 0) d = 0;
        if ($urandom_range(7) == 0) d = -d;
        case (a)
          0: begin q.sx = s; q.dx = d; q.lx = c - h; q.hx = c + h; end
          1: begin q.sy = s; q.dy = d; q.ly = c - h; q.hy = c + h; end
          default: begin q.sz = s; q.dz = d; q.lz = c - h; q.hz = c + h; end
        endcase
      end
      if ($urandom_range(9) == 0) begin
        tmp = q.lx; q.lx = q.hx; q.hx = tmp;
      end
    end else if (kind < 75) begin
      // tiny values make the boundary equalities common
      q = '{int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
            int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
            int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
            int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
            int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
            int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4};
    end else if (kind < 92) begin
      q = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      q = '{pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
            pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
            pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
    end
    return q;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 16;
    recv_idle_pct   = 57;

    // unit box, ray along x: hit, then heading away on each axis
    send_fields(-2 * ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(-2 * ONE, 0, 0, -ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(0, 3 * ONE, 0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(0, 0, -3 * ONE, ONE, ONE, -ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    // zero direction inside and outside
    send_fields(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(5 * ONE, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    // inverted boxes
    send_fields(0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_fields(ONE, 0, 0, 0, ONE, 0, 2 * ONE, ONE, ONE, 0, -ONE, -ONE);
    // cross-axis misses on yz, zx and xy
    send_fields(0, -3 * ONE, 0, 0, ONE, 3 * ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(-3 * ONE, 0, 0, ONE, 0, 3 * ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(-3 * ONE, 0, 0, ONE, 3 * ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(-3 * ONE, 0, 0, 2 * ONE, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_fields(-3, 1, 0, 2, 0, 0, -1, -1, -1, 1, 1, 1);
    // extreme coordinates
    send_fields(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_fields(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_fields(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_fields(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_fields(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_fields(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_fields(CMAX, CMAX, CMAX, CMIN, 1, CMAX, CMIN, CMIN, CMIN, CMIN + 1, CMIN + 1, 0);
    send_fields(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, -1, 0, -1, 0, -1);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      send_query(random_query());
      if (n == RAND_ITEMS / 2) hold_req++;
    end
    wait_drained();

    sender_idle_pct = 57;
    recv_idle_pct   = 16;
    for (int n = 0; n < RAND_ITEMS; n++) send_query(random_query());
    wait_drained();

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      send_query(random_query());
      if (n == RAND_ITEMS / 3) hold_req++;
    end
    wait_drained();
    repeat (3 * LATENCY) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("ray_box_overlap_test_tb passed");
    end else begin
      $display("ray_box_overlap_test_tb failed");
    end
    $finish;
  end

endmodule
